### hdl/iks_pkg.sv
// shared types and constants for the interpolation key search unit
package iks_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int KEY_W       = 32;
   localparam int CNT_W       = 32;
   localparam int SEG_W       = ADDR_W + 1;
   localparam int NUM_W       = KEY_W + ADDR_W;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_WRITE,
      DP_LOAD,
      DP_RD_LO,
      DP_RD_HI,
      DP_CHECK,
      DP_DIV_START,
      DP_DIV_STEP,
      DP_RD_PROBE,
      DP_COMPARE,
      DP_RESULT_MISS,
      DP_RESULT_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } iks_cmd_type;

   typedef struct packed {
      logic seg_empty;
      logic key_outside;
      logic probe_direct;
      logic div_done;
      logic probe_hit;
   } iks_status_type;

endpackage

### hdl/iks_ram.sv
// generic single port ram with registered read
module iks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/iks_datapath.sv
// key table, segment registers, restoring divider and probe counter
module iks_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  iks_pkg::iks_cmd_type             cmd,
   output iks_pkg::iks_status_type          status,
   input  logic [iks_pkg::ADDR_W-1:0]       req_entry_index,
   input  logic [iks_pkg::KEY_W-1:0]        req_key_value,
   input  logic [iks_pkg::ADDR_W-1:0]       req_lower_bound,
   input  logic [iks_pkg::ADDR_W-1:0]       req_upper_bound,
   output logic                             rsp_found,
   output logic [iks_pkg::ADDR_W-1:0]       rsp_found_index,
   output logic [iks_pkg::CNT_W-1:0]        rsp_probe_total
);

   localparam int AW = iks_pkg::ADDR_W;
   localparam int KW = iks_pkg::KEY_W;
   localparam int SW = iks_pkg::SEG_W;
   localparam int NW = iks_pkg::NUM_W;
   localparam int DW = $clog2(NW + 1);

   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [KW-1:0] klo_ff, klo_in, khi_ff, khi_in;
   logic [AW-1:0] probe_ff, probe_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [KW:0]   rem_ff, rem_in;
   logic [KW-1:0] den_ff, den_in;
   logic [DW-1:0] dcnt_ff, dcnt_in;
   logic [iks_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic [AW-1:0] fidx_ff, fidx_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [KW-1:0] ram_wdata, ram_rdata;
   logic [KW:0]   rem_shift;
   logic [SW-1:0] probe_sum;

   iks_ram #(.WIDTH(KW), .DEPTH(iks_pkg::TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign rem_shift = {rem_ff[KW-1:0], quo_ff[NW-1]};
   assign probe_sum = lo_ff + SW'(quo_ff[AW-1:0]);

   always_comb begin
      status.seg_empty    = (lo_ff > hi_ff) ||
                            (hi_ff > SW'(iks_pkg::TABLE_DEPTH - 1));
      status.key_outside  = (key_ff < klo_ff) || (key_ff > khi_ff);
      status.probe_direct = (lo_ff == hi_ff) || (klo_ff == khi_ff);
      status.div_done     = (dcnt_ff == '0);
      status.probe_hit    = (ram_rdata == key_ff);
   end

   always_comb begin
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      klo_in   = klo_ff;
      khi_in   = khi_ff;
      probe_in = probe_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dcnt_in  = dcnt_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      fidx_in  = fidx_ff;
      ram_we   = 1'b0;
      ram_addr = lo_ff[AW-1:0];
      ram_wdata = req_key_value;
      case (cmd.op)
         iks_pkg::DP_WRITE: begin
            ram_we   = 1'b1;
            ram_addr = req_entry_index;
         end
         iks_pkg::DP_RESULT_WRITE: begin
            found_in = 1'b0;
            fidx_in  = '0;
         end
         iks_pkg::DP_LOAD: begin
            key_in = req_key_value;
            lo_in  = {1'b0, req_lower_bound};
            hi_in  = {1'b0, req_upper_bound};
         end
         iks_pkg::DP_RD_LO: begin
            cnt_in   = cnt_ff + 1'b1;
            ram_addr = lo_ff[AW-1:0];
         end
         iks_pkg::DP_RD_HI: begin
            ram_addr = hi_ff[AW-1:0];
            klo_in   = ram_rdata;
         end
         iks_pkg::DP_CHECK: begin
            khi_in = ram_rdata;
         end
         iks_pkg::DP_DIV_START: begin
            quo_in  = NW'(key_ff - klo_ff) * NW'(hi_ff - lo_ff);
            rem_in  = '0;
            den_in  = khi_ff - klo_ff;
            dcnt_in = DW'(NW);
         end
         iks_pkg::DP_DIV_STEP: begin
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = rem_shift - {1'b0, den_ff};
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
         end
         iks_pkg::DP_RD_PROBE: begin
            if (status.probe_direct) begin
               probe_in = lo_ff[AW-1:0];
            end else begin
               probe_in = probe_sum[AW-1:0];
            end
            ram_addr = probe_in;
         end
         iks_pkg::DP_COMPARE: begin
            if (ram_rdata == key_ff) begin
               found_in = 1'b1;
               fidx_in  = probe_ff;
            end else if (ram_rdata < key_ff) begin
               lo_in = SW'(probe_ff) + 1'b1;
            end else begin
               hi_in = SW'(probe_ff) - 1'b1;
            end
         end
         iks_pkg::DP_RESULT_MISS: begin
            found_in = 1'b0;
            fidx_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      klo_ff   <= klo_in;
      khi_ff   <= khi_in;
      probe_ff <= probe_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      dcnt_ff  <= dcnt_in;
      found_ff <= found_in;
      fidx_ff  <= fidx_in;
   end

   assign rsp_found       = found_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_probe_total = cnt_ff;

endmodule

### hdl/iks_controller.sv
// sequencing state machine for writes and search probes
module iks_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_type,
   input  iks_pkg::iks_status_type status,
   output iks_pkg::iks_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_LO, S_RD_HI, S_CHECK, S_DIV_START, S_DIV,
      S_RD_PROBE, S_WAIT_PROBE, S_COMPARE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      cmd.op   = iks_pkg::DP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               busy_in = 1'b1;
               if (req_type == iks_pkg::REQ_WRITE) begin
                  cmd.op   = iks_pkg::DP_WRITE;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = iks_pkg::DP_LOAD;
                  state_in = S_RD_LO;
               end
            end
         end
         S_DONE: begin
            cmd.op   = iks_pkg::DP_RESULT_WRITE;
            valid_in = 1'b1;
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
         S_RD_LO: begin
            cmd.op = iks_pkg::DP_RD_LO;
            if (status.seg_empty) begin
               state_in = S_WAIT_PROBE;
            end else begin
               state_in = S_RD_HI;
            end
         end
         S_RD_HI: begin
            cmd.op   = iks_pkg::DP_RD_HI;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = iks_pkg::DP_CHECK;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            if (status.key_outside) begin
               cmd.op   = iks_pkg::DP_RESULT_MISS;
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = S_IDLE;
            end else if (status.probe_direct) begin
               state_in = S_RD_PROBE;
            end else begin
               cmd.op   = iks_pkg::DP_DIV_START;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_RD_PROBE;
            end else begin
               cmd.op = iks_pkg::DP_DIV_STEP;
            end
         end
         S_RD_PROBE: begin
            cmd.op   = iks_pkg::DP_RD_PROBE;
            state_in = S_COMPARE;
         end
         S_WAIT_PROBE: begin
            cmd.op   = iks_pkg::DP_RESULT_MISS;
            valid_in = 1'b1;
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
         S_COMPARE: begin
            cmd.op = iks_pkg::DP_COMPARE;
            if (status.probe_hit) begin
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD_LO;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

### hdl/interpolation_key_search_unit.sv
// top level of the interpolation key search unit
//
// usage
//   a request word is taken at a clock edge where start is high and busy low.
//   req_type selects a table write (key_value stored at entry_index) or a
//   search of key_value within [lower_bound, upper_bound] of the sorted table.
//   one result word per request appears for a single cycle with rsp_valid;
//   the receiver cannot stall, so the word must be captured in that cycle.
//   rsp_probe_total is the running count of probe steps since reset.
// sequence
//   a write stores key_value and then shows its result word.
//   a search repeats probe steps: table reads and control, plus the bit-serial
//   restoring divider, one quotient bit a cycle, when interpolating; the divider
//   is skipped when probing at the lower bound. a key outside the end keys or an
//   empty segment ends the search with a miss.
//   busy falls as the result word is shown, so the next request can be taken
//   at the edge that takes the result; one request at a time.
// reset
//   synchronous active high reset clears the controller and probe counter;
//   the key table is not cleared and must be written before it is searched.
module interpolation_key_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [iks_pkg::ADDR_W-1:0]        req_entry_index,
   input  logic [iks_pkg::KEY_W-1:0]         req_key_value,
   input  logic [iks_pkg::ADDR_W-1:0]        req_lower_bound,
   input  logic [iks_pkg::ADDR_W-1:0]        req_upper_bound,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [iks_pkg::ADDR_W-1:0]        rsp_found_index,
   output logic [iks_pkg::CNT_W-1:0]         rsp_probe_total
);

   iks_pkg::iks_cmd_type    cmd;
   iks_pkg::iks_status_type status;

   iks_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   iks_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_entry_index(req_entry_index),
      .req_key_value  (req_key_value),
      .req_lower_bound(req_lower_bound),
      .req_upper_bound(req_upper_bound),
      .rsp_found      (rsp_found),
      .rsp_found_index(rsp_found_index),
      .rsp_probe_total(rsp_probe_total)
   );

endmodule

### tb/interpolation_key_search_unit_test.sv
// testbench for the interpolation key search unit: scoreboard, stimulus and checks
`timescale 1ns / 100ps

class key_search_scoreboard;
   typedef struct {
      logic        found;
      logic [9:0]  index;
      logic [31:0] probes;
   } search_word_type;

   logic [31:0]     key_mem [iks_pkg::TABLE_DEPTH];
   logic [31:0]     probe_count;
   search_word_type pending_words [$];
   int              errors;

   function new();
      probe_count = '0;
      errors = 0;
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   function int interpolate_search(logic [31:0] key, int lo, int hi);
      logic [31:0]     klo, khi, kp;
      longint unsigned num, den;
      int              probe;
      forever begin
         probe_count = probe_count + 1;
         if (lo > hi || lo < 0 || hi >= iks_pkg::TABLE_DEPTH) return -1;
         klo = key_mem[lo];
         khi = key_mem[hi];
         if (key < klo || key > khi) return -1;
         if (lo == hi || klo == khi) begin
            probe = lo;
         end else begin
            num = longint'(key - klo) * longint'(hi - lo);
            den = longint'(khi - klo);
            probe = lo + int'(num / den);
         end
         kp = key_mem[probe];
         if (kp == key) return probe;
         if (kp < key) lo = probe + 1;
         else hi = probe - 1;
      end
   endfunction

   function void note(logic kind, logic [9:0] idx, logic [31:0] key,
                      logic [9:0] lb, logic [9:0] ub);
      search_word_type w;
      int              r;
      w.found = 1'b0;
      w.index = '0;
      if (kind == iks_pkg::REQ_WRITE) begin
         key_mem[idx] = key;
      end else begin
         r = interpolate_search(key, int'(lb), int'(ub));
         if (r >= 0) begin
            w.found = 1'b1;
            w.index = r[9:0];
         end
      end
      w.probes = probe_count;
      pending_words.push_back(w);
   endfunction

   task check(logic found, logic [9:0] index, logic [31:0] probes);
      search_word_type w;
      if (pending_words.size() == 0) begin
         report("unexpected word", 1, 0);
      end else begin
         w = pending_words.pop_front();
         if (found !== w.found) report("found", found, w.found);
         if (index !== w.index) report("found_index", index, w.index);
         if (probes !== w.probes) report("probe_total", probes, w.probes);
      end
   endtask
endclass

module interpolation_key_search_unit_test;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = iks_pkg::REQ_WRITE;
   logic [9:0]  req_entry_index = '0;
   logic [31:0] req_key_value = '0;
   logic [9:0]  req_lower_bound = '0;
   logic [9:0]  req_upper_bound = '0;
   logic        rsp_valid;
   logic        rsp_found;
   logic [9:0]  rsp_found_index;
   logic [31:0] rsp_probe_total;

   key_search_scoreboard sb = new();
   int burst_left = 0;

   interpolation_key_search_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4s;
      $display("interpolation_key_search_unit_test: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_found, rsp_found_index, rsp_probe_total);
   end

   task automatic send_word(logic kind, logic [9:0] idx, logic [31:0] key,
                            logic [9:0] lb, logic [9:0] ub);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = $urandom_range(8, 0);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_type = kind;
      req_entry_index = idx;
      req_key_value = key;
      req_lower_bound = lb;
      req_upper_bound = ub;
      do @(posedge clock); while (busy);
      sb.note(kind, idx, key, lb, ub);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_sorted(logic [9:0] idx);
      logic [31:0] lo, hi;
      lo = (idx > 0) ? sb.key_mem[idx - 1] : 32'h0;
      hi = (idx < 1023) ? sb.key_mem[idx + 1] : 32'hFFFF_FFFF;
      send_word(iks_pkg::REQ_WRITE, idx, (lo <= hi) ? $urandom_range(hi, lo) : lo,
                10'($urandom), 10'($urandom));
   endtask

   task automatic drain();
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] k;
      logic [9:0]  a, b, i;
      int          n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the table with sorted keys, a flat run and duplicates
      k = 32'h0;
      for (n = 0; n < 1024; n++) begin
         if (n == 1023) k = 32'hFFFF_FFFF;
         else if (n > 0 && !(n > 100 && n <= 110) && $urandom_range(7, 0) != 0)
            k = k + $urandom_range(4_000_000, 1);
         send_word(iks_pkg::REQ_WRITE, 10'(n), k, 10'($urandom), 10'($urandom));
      end

      // directed searches, with sorted rewrites of entries 512, 0 and 1023
      send_word(iks_pkg::REQ_SEARCH, 10'($urandom), 32'h0, 10'd0, 10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'($urandom), 32'hFFFF_FFFF, 10'd0, 10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'd1023, sb.key_mem[500], 10'd600, 10'd400);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[300], 10'd300, 10'd300);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[300] + 1, 10'd300, 10'd300);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[105], 10'd101, 10'd110);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[105] + 1, 10'd101, 10'd110);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[200] - 1, 10'd200, 10'd800);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[800] + 1, 10'd200, 10'd800);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[700], 10'd0, 10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[1022], 10'd1023, 10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'd0, sb.key_mem[0], 10'd1, 10'd0);
      write_sorted(10'd512);
      send_word(iks_pkg::REQ_SEARCH, 10'h3FF, sb.key_mem[512], 10'd0, 10'd1023);
      write_sorted(10'd0);
      write_sorted(10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'h2AA, 32'h5555_5555, 10'd0, 10'd1023);
      send_word(iks_pkg::REQ_SEARCH, 10'h155, 32'hAAAA_AAAA, 10'd0, 10'd1023);

      // pause until the block has drained
      drain();

      for (n = 0; n < 500; n++) begin
         if (n == 250) drain();
         case ($urandom_range(99, 0)) inside
            [0:27]: write_sorted(10'($urandom));
            [28:29]: send_word(iks_pkg::REQ_WRITE, 10'($urandom), $urandom,
                               10'($urandom), 10'($urandom));
            default: begin
               a = 10'($urandom);
               b = 10'($urandom);
               if ($urandom_range(9, 0) != 0 && a > b) begin
                  i = a; a = b; b = i;
               end
               if ($urandom_range(3, 0) == 0) begin
                  b = a + 10'($urandom_range(8, 0));
                  if (b < a) b = 10'd1023;
               end
               i = (a <= b) ? a + 10'($urandom_range(int'(b - a), 0)) : a;
               case ($urandom_range(3, 0))
                  0: k = $urandom;
                  1: k = sb.key_mem[i] + 1;
                  default: k = sb.key_mem[i];
               endcase
               send_word(iks_pkg::REQ_SEARCH, 10'($urandom), k, a, b);
            end
         endcase
      end

      @(negedge clock);
      start = 1'b0;
      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("interpolation_key_search_unit_test: PASS");
      end else begin
         $display("interpolation_key_search_unit_test: FAIL");
      end
      $finish;
   end
endmodule

### files.f
hdl/iks_pkg.sv
hdl/iks_ram.sv
hdl/iks_datapath.sv
hdl/iks_controller.sv
hdl/interpolation_key_search_unit.sv
tb/interpolation_key_search_unit_test.sv
